FILE: rtl/latched_alarm_monitor_top_macros.svh
// Assertion macros shared by the alarm monitor RTL.
`ifndef LATCHED_ALARM_MONITOR_TOP_MACROS_SVH
`define LATCHED_ALARM_MONITOR_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define LAM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define LAM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/lam_pkg.sv
// Types, codes and constants shared by the alarm monitor modules.
`default_nettype none

package lam_pkg;

  // Input operation codes
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_FRAME = 2'd1;
  localparam logic [1:0] OP_PRESS = 2'd2;

  // Frame type codes
  localparam logic [1:0] FT_ALERT     = 2'd1;
  localparam logic [1:0] FT_HEARTBEAT = 2'd2;

  typedef enum logic [1:0] {
    MON_IDLE    = 2'd0,
    MON_ALARM   = 2'd1,
    MON_OFFLINE = 2'd2,
    MON_LOWBATT = 2'd3
  } mon_state_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_LOW_BATT = 2'd0,
    CFG_TIMEOUT  = 2'd1,
    CFG_DEBOUNCE = 2'd2,
    CFG_VERSION  = 2'd3
  } cfg_idx_t;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [15:0] RST_LOW_BATT_MV = 16'd3300;
  localparam logic [31:0] RST_TIMEOUT_MS  = 32'd900000;
  localparam logic [15:0] RST_DEBOUNCE_MS = 16'd300;
  localparam logic [7:0]  RST_VERSION     = 8'd1;

  // Pattern periods in milliseconds
  localparam int ALARM_SLOT  = 250;
  localparam int ALARM_PER   = 2 * ALARM_SLOT;
  localparam int OFFL_PER    = 8000;
  localparam int LOWB_PER    = 30000;
  localparam int IDLE_PER    = 3000;

  localparam int PH_ALARM_W = $clog2(ALARM_PER);
  localparam int PH_OFFL_W  = $clog2(OFFL_PER);
  localparam int PH_LOWB_W  = $clog2(LOWB_PER);
  localparam int PH_IDLE_W  = $clog2(IDLE_PER);

  localparam logic [PH_ALARM_W-1:0] ALARM_ON_START = PH_ALARM_W'(ALARM_SLOT);
  localparam logic [PH_OFFL_W-1:0]  OFFL_CHIRP     = PH_OFFL_W'(80);
  localparam logic [PH_OFFL_W-1:0]  OFFL_GAP_END   = PH_OFFL_W'(200);
  localparam logic [PH_OFFL_W-1:0]  OFFL_CHIRP2_END = PH_OFFL_W'(280);
  localparam logic [PH_LOWB_W-1:0]  LOWB_CHIRP     = PH_LOWB_W'(80);
  localparam logic [PH_IDLE_W-1:0]  IDLE_BLINK     = PH_IDLE_W'(40);

  localparam logic [PH_ALARM_W-1:0] ALARM_PH_LAST = PH_ALARM_W'(ALARM_PER - 1);
  localparam logic [PH_OFFL_W-1:0]  OFFL_PH_LAST  = PH_OFFL_W'(OFFL_PER - 1);
  localparam logic [PH_LOWB_W-1:0]  LOWB_PH_LAST  = PH_LOWB_W'(LOWB_PER - 1);
  localparam logic [PH_IDLE_W-1:0]  IDLE_PH_LAST  = PH_IDLE_W'(IDLE_PER - 1);

  typedef struct packed {
    logic [7:0]  expected_version;
    logic [15:0] debounce_ms;
    logic [31:0] offline_timeout_ms;
    logic [15:0] low_battery_mv;
  } cfg_t;

  typedef struct packed {
    logic [15:0] frame_battery_mv;
    logic [31:0] frame_seq;
    logic [1:0]  frame_type;
    logic [7:0]  frame_version;
    logic [1:0]  operation;
  } in_item_t;

  typedef struct packed {
    logic                  ack_active;
    logic [31:0]           ack_seq;
    logic                  ack_valid;
    logic                  status_led_on;
    logic                  alarm_led_on;
    logic                  buzzer_on;
    mon_state_t            monitor_state;
  } result_t;

  // Millisecond clock and its pattern phases
  typedef struct packed {
    logic [31:0]           time_ms;
    logic [PH_ALARM_W-1:0] ph_alarm;
    logic [PH_OFFL_W-1:0]  ph_offl;
    logic [PH_LOWB_W-1:0]  ph_lowb;
    logic [PH_IDLE_W-1:0]  ph_idle;
  } tb_t;

  localparam int IN_ITEM_W  = $bits(in_item_t);
  localparam int IN_DATA_W  = ((IN_ITEM_W + 7) / 8) * 8;
  localparam int RESULT_W   = $bits(result_t);
  localparam int OUT_DATA_W = ((RESULT_W + 7) / 8) * 8;

endpackage

`default_nettype wire

FILE: rtl/lam_cfg.sv
// APB register file holding the monitor configuration.
`default_nettype none

module lam_cfg
  import lam_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready,
  output cfg_t                       cfg
);

  cfg_t     cfg_r;
  cfg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = cfg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.low_battery_mv     <= RST_LOW_BATT_MV;
      cfg_r.offline_timeout_ms <= RST_TIMEOUT_MS;
      cfg_r.debounce_ms        <= RST_DEBOUNCE_MS;
      cfg_r.expected_version   <= RST_VERSION;
    end else if (wr_en) begin
      unique case (idx)
        CFG_LOW_BATT: cfg_r.low_battery_mv     <= pwdata[15:0];
        CFG_TIMEOUT:  cfg_r.offline_timeout_ms <= pwdata[31:0];
        CFG_DEBOUNCE: cfg_r.debounce_ms        <= pwdata[15:0];
        CFG_VERSION:  cfg_r.expected_version   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      CFG_LOW_BATT: prdata = {16'd0, cfg_r.low_battery_mv};
      CFG_TIMEOUT:  prdata = cfg_r.offline_timeout_ms;
      CFG_DEBOUNCE: prdata = {16'd0, cfg_r.debounce_ms};
      CFG_VERSION:  prdata = {24'd0, cfg_r.expected_version};
      default:      prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/lam_timebase.sv
// Millisecond clock with running phase counters for the drive patterns.
`default_nettype none

module lam_timebase
  import lam_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic tick,
  output tb_t       tb_view
);

  tb_t tb_r;
  tb_t tb_nxt;

  // Phases restart together when the 32-bit clock wraps.
  always_comb begin
    tb_nxt = tb_r;
    if (tick) begin
      if (tb_r.time_ms == '1) begin
        tb_nxt = '0;
      end else begin
        tb_nxt.time_ms  = tb_r.time_ms + 32'd1;
        tb_nxt.ph_alarm = (tb_r.ph_alarm == ALARM_PH_LAST) ? '0 : tb_r.ph_alarm + 1'b1;
        tb_nxt.ph_offl  = (tb_r.ph_offl  == OFFL_PH_LAST)  ? '0 : tb_r.ph_offl  + 1'b1;
        tb_nxt.ph_lowb  = (tb_r.ph_lowb  == LOWB_PH_LAST)  ? '0 : tb_r.ph_lowb  + 1'b1;
        tb_nxt.ph_idle  = (tb_r.ph_idle  == IDLE_PH_LAST)  ? '0 : tb_r.ph_idle  + 1'b1;
      end
    end
  end

  assign tb_view = tb_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tb_r <= '0;
    end else begin
      tb_r <= tb_nxt;
    end
  end

`include "latched_alarm_monitor_top_macros.svh"

  `LAM_ASSERT_IMP(a_phase_range, 1'b1, (tb_r.ph_alarm <= ALARM_PH_LAST) && (tb_r.ph_offl <= OFFL_PH_LAST) && (tb_r.ph_lowb <= LOWB_PH_LAST) && (tb_r.ph_idle <= IDLE_PH_LAST), "phase counter out of range")
  `LAM_ASSERT_NXT(a_wrap_clears, tick && (tb_r.time_ms == '1), tb_r == '0, "clock wrap left a phase set")
  `LAM_ASSERT_IMP(a_zero_aligned, tb_r.time_ms == '0, tb_r == '0, "phases not aligned to time zero")

endmodule

`default_nettype wire

FILE: rtl/lam_core.sv
// Latch, liveness and battery state plus the per-item result decode.
`default_nettype none

module lam_core
  import lam_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     fire,
  input  wire in_item_t item,
  input  wire cfg_t     cfg,
  input  wire tb_t      tb,
  output result_t       result
);

  logic [31:0] last_frame_r, last_frame_nxt;
  logic [31:0] last_press_r, last_press_nxt;
  logic        batt_low_r, batt_low_nxt;
  logic        latched_r, latched_nxt;
  logic [31:0] latched_seq_r, latched_seq_nxt;
  logic [31:0] cleared_seq_r, cleared_seq_nxt;

  logic        frame_ok;
  logic        press_ok;
  logic        is_alert;
  logic        is_hb;
  logic        alert_new;
  logic [31:0] since_press;
  logic [31:0] since_frame;
  mon_state_t  mon;
  logic        buzz, aled, sled;

  assign frame_ok    = (item.operation == OP_FRAME) &&
                       (item.frame_version == cfg.expected_version);
  assign is_alert    = frame_ok && (item.frame_type == FT_ALERT);
  assign is_hb       = frame_ok && (item.frame_type == FT_HEARTBEAT);
  assign alert_new   = is_alert && (item.frame_seq != cleared_seq_r);
  assign since_press = tb.time_ms - last_press_r;
  assign press_ok    = (item.operation == OP_PRESS) &&
                       (since_press > {16'd0, cfg.debounce_ms});

  always_comb begin
    last_frame_nxt  = last_frame_r;
    last_press_nxt  = last_press_r;
    batt_low_nxt    = batt_low_r;
    latched_nxt     = latched_r;
    latched_seq_nxt = latched_seq_r;
    cleared_seq_nxt = cleared_seq_r;
    if (frame_ok) begin
      last_frame_nxt = tb.time_ms;
      if (item.frame_battery_mv != '0) begin
        batt_low_nxt = item.frame_battery_mv < cfg.low_battery_mv;
      end
      if (alert_new) begin
        latched_nxt     = 1'b1;
        latched_seq_nxt = item.frame_seq;
      end
    end
    if (press_ok) begin
      last_press_nxt = tb.time_ms;
      if (latched_r) begin
        latched_nxt     = 1'b0;
        cleared_seq_nxt = latched_seq_r;
      end
    end
  end

  assign since_frame = tb.time_ms - last_frame_nxt;

  always_comb begin
    if (latched_nxt) begin
      mon = MON_ALARM;
    end else if (since_frame > cfg.offline_timeout_ms) begin
      mon = MON_OFFLINE;
    end else if (batt_low_nxt) begin
      mon = MON_LOWBATT;
    end else begin
      mon = MON_IDLE;
    end
  end

  always_comb begin
    buzz = 1'b0;
    aled = 1'b0;
    sled = 1'b0;
    unique case (mon)
      MON_ALARM: begin
        aled = 1'b1;
        sled = 1'b1;
        buzz = tb.ph_alarm >= ALARM_ON_START;
      end
      MON_OFFLINE: begin
        buzz = (tb.ph_offl < OFFL_CHIRP) ||
               ((tb.ph_offl > OFFL_GAP_END) && (tb.ph_offl < OFFL_CHIRP2_END));
        sled = buzz;
      end
      MON_LOWBATT: begin
        buzz = tb.ph_lowb < LOWB_CHIRP;
        sled = buzz;
      end
      default: begin
        sled = tb.ph_idle < IDLE_BLINK;
      end
    endcase
  end

  always_comb begin
    result.monitor_state    = mon;
    result.buzzer_on        = buzz;
    result.alarm_led_on     = aled;
    result.status_led_on    = sled;
    result.ack_valid        = is_alert || is_hb;
    result.ack_seq          = (is_alert || is_hb) ? item.frame_seq : '0;
    result.ack_active       = alert_new;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_frame_r  <= '0;
      last_press_r  <= '0;
      batt_low_r    <= 1'b0;
      latched_r     <= 1'b0;
      latched_seq_r <= '0;
      cleared_seq_r <= '0;
    end else if (fire) begin
      last_frame_r  <= last_frame_nxt;
      last_press_r  <= last_press_nxt;
      batt_low_r    <= batt_low_nxt;
      latched_r     <= latched_nxt;
      latched_seq_r <= latched_seq_nxt;
      cleared_seq_r <= cleared_seq_nxt;
    end
  end

`include "latched_alarm_monitor_top_macros.svh"

  `LAM_ASSERT_NXT(a_press_clears, fire && press_ok && latched_r, !latched_r && (cleared_seq_r == $past(latched_seq_r)), "press did not clear latch")
  `LAM_ASSERT_IMP(a_latch_not_cleared, latched_r, latched_seq_r != cleared_seq_r, "latched sequence equals cleared one")
  `LAM_ASSERT_IMP(a_active_needs_ack, result.ack_active, result.ack_valid && (result.monitor_state == MON_ALARM), "active ack without alarm")

endmodule

`default_nettype wire

FILE: rtl/latched_alarm_monitor_top.sv
// Top level of the latched alarm monitor: stream channels, APB config, pipeline.
//
// Usage:
//   in_*  : one transaction per item: a millisecond tick, a received frame or
//           a clear-button press (operation code in tdata).
//   out_* : exactly one result transaction per input item, in order: priority
//           state (alarm > offline > low battery > idle), buzzer and LED drive
//           for the current millisecond, and the acknowledgement fields.
//   cfg_* : APB registers at byte 0 low_battery_mv, 4 offline_timeout_ms,
//           8 debounce_ms, 12 expected_version; write only while idle.
// Timing: an item taken into the input register is processed into the result
//   register, which drives out_*; one item per cycle sustained while out_tready
//   is high. Per item, one pass of compare and subtract logic lies between the
//   input and result registers; the pattern phases are kept as running counters.
// Reset: synchronous rst_n restores the register defaults and clears the
//   clock, latch and flags; the channels come up empty.
// Stall: while out_tready is low the result holds and the input register can
//   still take one more item; in_tready drops only when both are full.
`default_nettype none

module latched_alarm_monitor_top
  import lam_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // tdata: operation[1:0], frame_version[9:2], frame_type[11:10],
  //        frame_seq[43:12], frame_battery_mv[59:44], zero fill above
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // tdata: monitor_state[1:0], buzzer_on[2], alarm_led_on[3], status_led_on[4],
  //        ack_valid[5], ack_seq[37:6], ack_active[38], zero fill above
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic      [OUT_DATA_W-1:0] out_tdata,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [CFG_DATA_W-1:0] cfg_prdata,
  output logic                       cfg_pready
);

  cfg_t     cfg;
  tb_t      tb;
  result_t  result;

  in_item_t item_r;
  logic     item_vld_r;
  result_t  res_r;
  logic     res_vld_r;

  logic     advance;
  logic     fire;
  logic     in_acc;

  // Result register free or being drained this cycle.
  assign advance   = !res_vld_r || out_tready;
  assign fire      = item_vld_r && advance;
  assign in_tready = !item_vld_r || advance;
  assign in_acc    = in_tvalid && in_tready;

  lam_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // Advance the millisecond clock only when a tick item is processed.
  lam_timebase u_timebase (
    .clk     (clk),
    .rst_n   (rst_n),
    .tick    (fire && (item_r.operation == OP_TICK)),
    .tb_view (tb)
  );

  lam_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (item_r),
    .cfg    (cfg),
    .tb     (tb),
    .result (result)
  );

  // Input register: load on accept, drop once processed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_acc) begin
      item_vld_r <= 1'b1;
    end else if (fire) begin
      item_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r <= in_tdata[IN_ITEM_W-1:0];
    end
  end

  // Result register: hold while the receiver stalls.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else if (fire) begin
      res_vld_r <= 1'b1;
    end else if (out_tready) begin
      res_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= result;
    end
  end

  assign out_tvalid = res_vld_r;
  assign out_tdata  = {{(OUT_DATA_W - RESULT_W){1'b0}}, res_r};

endmodule

`default_nettype wire

FILE: tb/latched_alarm_monitor_top_tb.sv
// Self-checking stream testbench for the latched alarm monitor with its own predictor.
module latched_alarm_monitor_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lam_pkg::*;

  // Codes the package leaves unnamed: the spare operation and the other frame types
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [1:0] FT_OTHER  = 2'd0;
  localparam logic [1:0] FT_UNUSED = 2'd3;

  localparam int CLK_HALF        = 5;
  localparam int IDLE_PCT        = 17;   // chance in a hundred that a side idles
  localparam int HOLD_OFF_CYCLES = 64;   // long receiver stall, enough to back up the input
  localparam int PHASE_ITEMS     = 360;  // random items per configuration phase
  localparam int SETTLE_CYCLES   = 4;    // margin after the last result comes back
  localparam int REPORT_LIMIT    = 10;
  // Longest correct quiet stretch is the receiver hold-off plus a sender gap and a
  // register access; the limit allows many times that.
  localparam int WATCHDOG_LIMIT  = 2000;

  typedef struct {
    in_item_t item;
    bit       pinned;   // expected result typed in below, not predicted
    result_t  want;
  } directed_row_t;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata    = '0;
  logic                  out_tvalid;
  logic                  out_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr   = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata  = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  // Shared controls between the stimulus and the result sink
  bit gaps_on          = 1'b1;
  bit hold_off_request = 1'b0;

  // Predictor copy of the registers and of the monitor state
  cfg_t        settings;
  logic [31:0] now_ms;
  logic [31:0] heard_ms;
  logic [31:0] pressed_ms;
  logic [31:0] latched_seq;
  logic [31:0] cleared_seq;
  logic        batt_low;
  logic        latched;

  result_t awaited_results [$];
  int      mismatch_count = 0;

  latched_alarm_monitor_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #CLK_HALF clk = ~clk;

  // Bring the predictor to the state the block holds after reset.
  task automatic clear_model();
    settings.low_battery_mv     = RST_LOW_BATT_MV;
    settings.offline_timeout_ms = RST_TIMEOUT_MS;
    settings.debounce_ms        = RST_DEBOUNCE_MS;
    settings.expected_version   = RST_VERSION;
    now_ms      = '0;
    heard_ms    = '0;
    pressed_ms  = '0;
    latched_seq = '0;
    cleared_seq = '0;
    batt_low    = 1'b0;
    latched     = 1'b0;
  endtask

  // Advance the monitor state by one item and form the result it yields.
  function automatic result_t monitor_outcome(input in_item_t it);
    result_t     r;
    logic [31:0] elapsed;
    logic [31:0] phase;
    r = '0;
    case (it.operation)
      OP_TICK: now_ms = now_ms + 32'd1;
      OP_FRAME: begin
        // Drop frames of any other version without touching the state.
        if (it.frame_version == settings.expected_version) begin
          heard_ms = now_ms;
          if (it.frame_battery_mv != 16'd0)
            batt_low = it.frame_battery_mv < settings.low_battery_mv;
          if (it.frame_type == FT_ALERT) begin
            r.ack_valid  = 1'b1;
            r.ack_seq    = it.frame_seq;
            r.ack_active = it.frame_seq != cleared_seq;
            if (r.ack_active) begin
              latched     = 1'b1;
              latched_seq = it.frame_seq;
            end
          end else if (it.frame_type == FT_HEARTBEAT) begin
            r.ack_valid = 1'b1;
            r.ack_seq   = it.frame_seq;
          end
        end
      end
      OP_PRESS: begin
        elapsed = now_ms - pressed_ms;
        if (elapsed > {16'd0, settings.debounce_ms}) begin
          pressed_ms = now_ms;
          if (latched) begin
            latched     = 1'b0;
            cleared_seq = latched_seq;
          end
        end
      end
      default: ;
    endcase

    elapsed = now_ms - heard_ms;
    if (latched)
      r.monitor_state = MON_ALARM;
    else if (elapsed > settings.offline_timeout_ms)
      r.monitor_state = MON_OFFLINE;
    else if (batt_low)
      r.monitor_state = MON_LOWBATT;
    else
      r.monitor_state = MON_IDLE;

    case (r.monitor_state)
      MON_ALARM: begin
        r.alarm_led_on  = 1'b1;
        r.status_led_on = 1'b1;
        r.buzzer_on     = ((now_ms / ALARM_SLOT) % 2) != 0;
      end
      MON_OFFLINE: begin
        phase           = now_ms % OFFL_PER;
        r.buzzer_on     = (phase < OFFL_CHIRP) ||
                          (phase > OFFL_GAP_END && phase < OFFL_CHIRP2_END);
        r.status_led_on = r.buzzer_on;
      end
      MON_LOWBATT: begin
        r.buzzer_on     = (now_ms % LOWB_PER) < LOWB_CHIRP;
        r.status_led_on = r.buzzer_on;
      end
      default: r.status_led_on = (now_ms % IDLE_PER) < IDLE_BLINK;
    endcase
    return r;
  endfunction

  function automatic in_item_t item_of(input logic [1:0] op, input logic [7:0] ver,
                                       input logic [1:0] typ, input logic [31:0] seq,
                                       input logic [15:0] batt);
    in_item_t it;
    it.operation        = op;
    it.frame_version    = ver;
    it.frame_type       = typ;
    it.frame_seq        = seq;
    it.frame_battery_mv = batt;
    return it;
  endfunction

  function automatic result_t result_of(input mon_state_t st, input bit buzz,
                                        input bit aled, input bit sled, input bit ackv,
                                        input logic [31:0] seq, input bit active);
    result_t r;
    r.monitor_state = st;
    r.buzzer_on     = buzz;
    r.alarm_led_on  = aled;
    r.status_led_on = sled;
    r.ack_valid     = ackv;
    r.ack_seq       = seq;
    r.ack_active    = active;
    return r;
  endfunction

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
        $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
    end
  endtask

  // Offer one item, hold it until the block takes it, then queue its result.
  // Called and returns right after a rising edge.
  task automatic send_item(input in_item_t it, input bit pinned, input result_t pinned_result);
    result_t predicted;
    // Idle step by step, each step with the same small chance.
    while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_DATA_W'(it);
    do @(posedge clk); while (!in_tready);
    predicted = monitor_outcome(it);
    awaited_results.push_back(pinned ? pinned_result : predicted);
  endtask

  // Pause the sender until every queued result has come back, then let the pipe settle.
  task automatic wait_for_quiet();
    in_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write one register over APB, mirror it in the predictor, then read it back.
  task automatic write_register(input cfg_idx_t idx, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_ADDR_W'({idx, 2'b00});
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      CFG_LOW_BATT: settings.low_battery_mv     = value[15:0];
      CFG_TIMEOUT:  settings.offline_timeout_ms = value;
      CFG_DEBOUNCE: settings.debounce_ms        = value[15:0];
      CFG_VERSION:  settings.expected_version   = value[7:0];
      default: ;
    endcase
    // Keep psel up and start the read-back with a fresh setup cycle.
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    check_field("register readback", value, cfg_prdata);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Random items, frames mostly accepted, sequences that hit the latched and cleared values
  // often enough to exercise re-alerts of a cleared sequence.
  function automatic in_item_t random_item();
    in_item_t it;
    int       pick;
    it.frame_version = ($urandom_range(99) < 80) ? settings.expected_version : 8'($urandom);
    pick = $urandom_range(99);
    it.frame_type = (pick < 40) ? FT_ALERT : (pick < 70) ? FT_HEARTBEAT :
                    (pick < 85) ? FT_OTHER : FT_UNUSED;
    pick = $urandom_range(99);
    it.frame_seq = (pick < 25) ? latched_seq : (pick < 40) ? cleared_seq : $urandom;
    pick = $urandom_range(99);
    if (pick < 30)
      it.frame_battery_mv = '0;
    else if (pick < 60)
      it.frame_battery_mv = settings.low_battery_mv + 16'($urandom_range(2)) - 16'd1;
    else
      it.frame_battery_mv = 16'($urandom);
    pick = $urandom_range(99);
    it.operation = (pick < 45) ? OP_TICK : (pick < 80) ? OP_FRAME :
                   (pick < 95) ? OP_PRESS : OP_UNUSED;
    return it;
  endfunction

  // Random items, now and then a long run of ticks to reach timeouts and patterns.
  task automatic run_random(input int count);
    int       ticks_left;
    in_item_t it;
    ticks_left = 0;
    for (int n = 0; n < count; n++) begin
      if (ticks_left == 0 && $urandom_range(99) < 1)
        ticks_left = $urandom_range(300, 20);
      it = random_item();
      if (ticks_left > 0) begin
        it.operation = OP_TICK;
        ticks_left--;
      end
      send_item(it, 1'b0, '0);
    end
  endtask

  // Result sink: random back-pressure, one long hold-off on request.
  initial begin : result_sink
    forever begin
      @(posedge clk);
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        out_tready <= !(gaps_on && $urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // Compare every result transaction, field by field, with the oldest expectation.
  always @(posedge clk) begin : result_check
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = result_t'(out_tdata[RESULT_W-1:0]);
      if (awaited_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("%0t: result 0x%0h arrived with nothing awaited", $realtime, out_tdata);
      end else begin
        want = awaited_results.pop_front();
        check_field("monitor_state", want.monitor_state, got.monitor_state);
        check_field("buzzer_on", want.buzzer_on, got.buzzer_on);
        check_field("alarm_led_on", want.alarm_led_on, got.alarm_led_on);
        check_field("status_led_on", want.status_led_on, got.status_led_on);
        check_field("ack_valid", want.ack_valid, got.ack_valid);
        check_field("ack_seq", want.ack_seq, got.ack_seq);
        check_field("ack_active", want.ack_active, got.ack_active);
      end
    end
  end

  // Watchdog: end the run once nothing has moved for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_psel && cfg_penable))
        quiet = 0;
      else
        quiet++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    directed_row_t rows [$];
    cfg_t          phase_settings [4];

    clear_model();

    // Directed rows under the reset settings; the clock stands at one after the first tick.
    rows.push_back('{item_of(OP_TICK, 8'd0, FT_OTHER, '0, '0), 1'b1,
                     result_of(MON_IDLE, 0, 0, 1, 0, '0, 0)});
    // Spare operation with every field at its top: nothing changes.
    rows.push_back('{item_of(OP_UNUSED, 8'hFF, FT_UNUSED, '1, '1), 1'b1,
                     result_of(MON_IDLE, 0, 0, 1, 0, '0, 0)});
    // Alert with sequence zero matches the cleared sequence after reset.
    rows.push_back('{item_of(OP_FRAME, 8'd1, FT_ALERT, '0, '0), 1'b1,
                     result_of(MON_IDLE, 0, 0, 1, 1, '0, 0)});
    // Wrong versions at both extremes: ignored entirely.
    rows.push_back('{item_of(OP_FRAME, 8'd0, FT_ALERT, '1, 16'd1), 1'b1,
                     result_of(MON_IDLE, 0, 0, 1, 0, '0, 0)});
    rows.push_back('{item_of(OP_FRAME, 8'hFF, FT_HEARTBEAT, '1, 16'd1), 1'b1,
                     result_of(MON_IDLE, 0, 0, 1, 0, '0, 0)});
    rows.push_back('{item_of(OP_FRAME, 8'd1, FT_HEARTBEAT, '1, '1), 1'b1,
                     result_of(MON_IDLE, 0, 0, 1, 1, '1, 0)});
    // Other frame type still updates the battery flag, but gets no acknowledgement.
    rows.push_back('{item_of(OP_FRAME, 8'd1, FT_OTHER, 32'd5, 16'd1), 1'b1,
                     result_of(MON_LOWBATT, 1, 0, 1, 0, '0, 0)});
    rows.push_back('{item_of(OP_FRAME, 8'd1, FT_UNUSED, 32'd9, 16'd3299), 1'b0, '0});
    rows.push_back('{item_of(OP_FRAME, 8'd1, FT_HEARTBEAT, 32'd7, 16'd3300), 1'b0, '0});
    rows.push_back('{item_of(OP_PRESS, 8'd0, FT_OTHER, '0, '0), 1'b0, '0});
    rows.push_back('{item_of(OP_FRAME, 8'd1, FT_ALERT, '1, '0), 1'b1,
                     result_of(MON_ALARM, 0, 1, 1, 1, '1, 1)});
    rows.push_back('{item_of(OP_FRAME, 8'd1, FT_ALERT, 32'h1234_5678, '0), 1'b0, '0});
    rows.push_back('{item_of(OP_TICK, 8'hFF, FT_UNUSED, '1, '1), 1'b0, '0});
    // Press inside the debounce window: latch holds.
    rows.push_back('{item_of(OP_PRESS, 8'hFF, FT_UNUSED, '1, '1), 1'b0, '0});
    rows.push_back('{item_of(OP_FRAME, 8'd1, FT_ALERT, '0, 16'hFFFF), 1'b0, '0});

    // Later settings: both extremes of every register, then two ordinary mixes.
    phase_settings[0] = '{expected_version: 8'd0, debounce_ms: 16'd0,
                          offline_timeout_ms: 32'd0, low_battery_mv: 16'hFFFF};
    phase_settings[1] = '{expected_version: 8'hFF, debounce_ms: 16'hFFFF,
                          offline_timeout_ms: 32'hFFFF_FFFF, low_battery_mv: 16'd0};
    phase_settings[2] = '{expected_version: 8'h5A, debounce_ms: 16'd25,
                          offline_timeout_ms: 32'd150, low_battery_mv: 16'd3300};
    phase_settings[3] = '{expected_version: 8'd1, debounce_ms: 16'd300,
                          offline_timeout_ms: 32'd60, low_battery_mv: 16'd40000};

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i])
      send_item(rows[i].item, rows[i].pinned, rows[i].want);
    run_random(PHASE_ITEMS);

    foreach (phase_settings[p]) begin
      wait_for_quiet();
      write_register(CFG_LOW_BATT, 32'(phase_settings[p].low_battery_mv));
      write_register(CFG_TIMEOUT, phase_settings[p].offline_timeout_ms);
      write_register(CFG_DEBOUNCE, 32'(phase_settings[p].debounce_ms));
      write_register(CFG_VERSION, 32'(phase_settings[p].expected_version));
      // Drop idling on both sides for one whole phase; stall the sink hard in another.
      gaps_on = (p != 2);
      if (p == 0)
        hold_off_request = 1'b1;
      run_random(PHASE_ITEMS);
    end

    wait_for_quiet();
    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/lam_pkg.sv
rtl/lam_cfg.sv
rtl/lam_timebase.sv
rtl/lam_core.sv
rtl/latched_alarm_monitor_top.sv
tb/latched_alarm_monitor_top_tb.sv
